>>> rtl/smd_pkg.sv
// Shared types, sizes and helpers for the sorted merge with duplicate removal.
// No dependencies; smd_ctrl, smd_checker and the top level import this package.
`timescale 1ns / 1ps

package smd_pkg;

    localparam int MAX_SIZE = 32;
    localparam int KEY_W    = 32;
    localparam int CAP_W    = 6;
    localparam int IDX_W    = $clog2(MAX_SIZE);
    localparam int CNT_W    = $clog2(MAX_SIZE + 1);

    typedef enum logic [1:0] {
        OP_FRONT = 2'd0,
        OP_CAND  = 2'd1,
        OP_MERGE = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP
    } state_t;

    // one access of a key memory: write port and read port
    typedef struct packed {
        logic                    wr_en;
        logic [IDX_W-1:0]        wr_addr;
        logic signed [KEY_W-1:0] wr_data;
        logic                    rd_en;
        logic [IDX_W-1:0]        rd_addr;
    } ram_req_t;

    // clamp the capacity register to 1 .. MAX_SIZE
    function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
        logic [CNT_W-1:0] res;
        if (cap == '0) begin
            res = CNT_W'(1);
        end
        else if (int'(cap) > MAX_SIZE) begin
            res = CNT_W'(MAX_SIZE);
        end
        else begin
            res = CNT_W'(cap);
        end
        return res;
    endfunction

endpackage

>>> rtl/sorted_merge_dedup.sv
// Top level: sorted merge of a front and a candidate key list with duplicate removal.
// Depends on smd_pkg, smd_ram (two key memories) and smd_ctrl (sequencer, output register).
`timescale 1ns / 1ps

// Channel   Direction  Signals                         Contents
// s_axis    in         tvalid tready tuser tdata       tuser = op, tdata = key
// m_axis    out        tvalid tready tlast tuser tdata tdata = merged_key,
//                                                      tlast = last, tuser = empty_res
// cfg       in         we wdata                        capacity register
//
// A load request writes the key to its memory at the list's count while the count is
// below capacity. A merge request reads both heads (ST_READ) and then compares and
// emits (ST_CMP) for each result, up to capacity results. The input stays stalled
// from a merge request until its last result is in the output register; a waiting
// result does not block the next load request. Reset clears both counts and sets
// capacity to its full value; key memories are not cleared, only entries below a
// count are ever used.

module sorted_merge_dedup
    import smd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,      // [5:0] capacity
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [KEY_W-1:0] s_axis_tdata,   // [31:0] key
    input  logic [1:0]       s_axis_tuser,   // [1:0] op
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [KEY_W-1:0] m_axis_tdata,   // [31:0] merged_key
    output logic             m_axis_tlast,   // last
    output logic             m_axis_tuser    // [0] empty_res
);

    ram_req_t                front_req, cand_req;
    logic signed [KEY_W-1:0] front_rd_data, cand_rd_data;
    logic signed [KEY_W-1:0] out_key;

    // front list keys
    smd_ram #(
        .DEPTH (MAX_SIZE),
        .WIDTH (KEY_W)
    ) u_front_ram (
        .clk     (clk),
        .wr_en   (front_req.wr_en),
        .wr_addr (front_req.wr_addr),
        .wr_data (front_req.wr_data),
        .rd_en   (front_req.rd_en),
        .rd_addr (front_req.rd_addr),
        .rd_data (front_rd_data)
    );

    // candidate list keys
    smd_ram #(
        .DEPTH (MAX_SIZE),
        .WIDTH (KEY_W)
    ) u_cand_ram (
        .clk     (clk),
        .wr_en   (cand_req.wr_en),
        .wr_addr (cand_req.wr_addr),
        .wr_data (cand_req.wr_data),
        .rd_en   (cand_req.rd_en),
        .rd_addr (cand_req.rd_addr),
        .rd_data (cand_rd_data)
    );

    // sequence loads and the two-pointer merge, hold results for the sink
    smd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_op         (s_axis_tuser),
        .in_key        (s_axis_tdata),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_key       (out_key),
        .out_last      (m_axis_tlast),
        .out_empty     (m_axis_tuser),
        .front_req     (front_req),
        .cand_req      (cand_req),
        .front_rd_data (front_rd_data),
        .cand_rd_data  (cand_rd_data)
    );

    assign m_axis_tdata = out_key;

endmodule

>>> rtl/smd_ram.sv
// Generic single-port-write, single-port-read synchronous RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module smd_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold the last read word while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/smd_ctrl.sv
// Load and merge sequencer with the result output register.
// Depends on smd_pkg; drives two smd_ram key memories through ram_req_t.
`timescale 1ns / 1ps

module smd_ctrl
    import smd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CAP_W-1:0]        cfg_wdata,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              in_op,
    input  logic signed [KEY_W-1:0] in_key,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [KEY_W-1:0] out_key,
    output logic                    out_last,
    output logic                    out_empty,
    output ram_req_t                front_req,
    output ram_req_t                cand_req,
    input  logic signed [KEY_W-1:0] front_rd_data,
    input  logic signed [KEY_W-1:0] cand_rd_data
);

    state_t                  state_reg, state_next;
    logic [CAP_W-1:0]        cap_reg;
    logic [CNT_W-1:0]        front_cnt_reg, front_cnt_next;
    logic [CNT_W-1:0]        cand_cnt_reg, cand_cnt_next;
    logic [CNT_W-1:0]        fi_reg, fi_next;
    logic [CNT_W-1:0]        ci_reg, ci_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [KEY_W-1:0] out_key_reg, out_key_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_empty_reg, out_empty_next;

    logic [CNT_W-1:0]        ecap;
    logic                    accept;
    op_t                     op;
    logic                    out_free;
    logic                    f_has, c_has;
    logic                    take_f, take_c, is_empty;
    logic signed [KEY_W-1:0] pick_key;
    logic [CNT_W-1:0]        fi_adv, ci_adv, n_adv;
    logic                    is_last;

    assign ecap     = eff_cap(cap_reg);
    assign op       = op_t'(in_op);
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // head selection for the merge step
    always_comb
    begin
        f_has    = fi_reg < front_cnt_reg;
        c_has    = ci_reg < cand_cnt_reg;
        take_f   = 1'b0;
        take_c   = 1'b0;
        is_empty = 1'b0;
        pick_key = cand_rd_data;
        priority if (f_has && c_has)
        begin
            if (front_rd_data < cand_rd_data)
            begin
                take_f   = 1'b1;
                pick_key = front_rd_data;
            end
            else if (cand_rd_data < front_rd_data)
            begin
                take_c = 1'b1;
            end
            else
            begin
                take_f = 1'b1;
                take_c = 1'b1;
            end
        end
        else if (f_has)
        begin
            take_f   = 1'b1;
            pick_key = front_rd_data;
        end
        else if (c_has)
        begin
            take_c = 1'b1;
        end
        else
        begin
            is_empty = 1'b1;
            pick_key = '0;
        end
        fi_adv  = fi_reg + CNT_W'(take_f);
        ci_adv  = ci_reg + CNT_W'(take_c);
        n_adv   = n_reg + CNT_W'(1);
        is_last = is_empty || (n_adv >= ecap)
                  || !((fi_adv < front_cnt_reg) || (ci_adv < cand_cnt_reg));
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (op == OP_MERGE))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                if (out_free)
                begin
                    state_next = is_last ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        front_cnt_next = front_cnt_reg;
        cand_cnt_next  = cand_cnt_reg;
        fi_next        = fi_reg;
        ci_next        = ci_reg;
        n_next         = n_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_key_next   = out_key_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;

        front_req         = '0;
        front_req.wr_addr = front_cnt_reg[IDX_W-1:0];
        front_req.wr_data = in_key;
        front_req.rd_addr = fi_reg[IDX_W-1:0];
        cand_req          = '0;
        cand_req.wr_addr  = cand_cnt_reg[IDX_W-1:0];
        cand_req.wr_data  = in_key;
        cand_req.rd_addr  = ci_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op)
                        OP_FRONT:
                        begin
                            if (front_cnt_reg < ecap)
                            begin
                                front_req.wr_en = 1'b1;
                                front_cnt_next  = front_cnt_reg + CNT_W'(1);
                            end
                        end
                        OP_CAND:
                        begin
                            if (cand_cnt_reg < ecap)
                            begin
                                cand_req.wr_en = 1'b1;
                                cand_cnt_next  = cand_cnt_reg + CNT_W'(1);
                            end
                        end
                        OP_MERGE:
                        begin
                            fi_next = '0;
                            ci_next = '0;
                            n_next  = '0;
                        end
                        OP_NONE:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                front_req.rd_en = 1'b1;
                cand_req.rd_en  = 1'b1;
            end
            ST_CMP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_key_next   = pick_key;
                    out_last_next  = is_last;
                    out_empty_next = is_empty;
                    fi_next        = fi_adv;
                    ci_next        = ci_adv;
                    n_next         = n_adv;
                    if (is_last)
                    begin
                        front_cnt_next = '0;
                        cand_cnt_next  = '0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_W'(MAX_SIZE);
            front_cnt_reg <= '0;
            cand_cnt_reg  <= '0;
            fi_reg        <= '0;
            ci_reg        <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            front_cnt_reg <= front_cnt_next;
            cand_cnt_reg  <= cand_cnt_next;
            fi_reg        <= fi_next;
            ci_reg        <= ci_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_key_reg   <= out_key_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    assign out_valid = out_valid_reg;
    assign out_key   = out_key_reg;
    assign out_last  = out_last_reg;
    assign out_empty = out_empty_reg;

endmodule

>>> rtl/smd_checker.sv
// Port-level checks for sorted_merge_dedup, attached by bind.
// Depends on smd_pkg for the op codes.
`timescale 1ns / 1ps

module smd_checker
    import smd_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [1:0]       s_axis_tuser,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [KEY_W-1:0] m_axis_tdata,
    input logic             m_axis_tlast,
    input logic             m_axis_tuser
);

    // an empty merge gives a single, final, zero result
    a_empty_final: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tlast && (m_axis_tdata == '0)))
        else $error("empty result not final or not zero");

    // a merge request stalls the input on the next cycle
    a_merge_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_MERGE)) |=> !s_axis_tready)
        else $error("input not stalled after merge request");

    // while a merge run is still open, no new request is taken
    a_run_open: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> !s_axis_tready)
        else $error("input ready in the middle of a merge run");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
             && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind sorted_merge_dedup smd_checker u_smd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
